/* rtl/fme_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fme_pkg
// Shared widths, codes and types of the fuzzy membership evaluator.
// ----------------------------------------------------------------------------
package fme_pkg;

   localparam int IN_W     = 16;
   localparam int OUT_FRAC = 15;
   localparam int OUT_W    = OUT_FRAC + 1;
   localparam int SCALE    = OUT_FRAC + 1;
   localparam int SQ_W     = 2 * IN_W;
   localparam int REM_W    = SQ_W + SCALE;
   localparam int QUOT_W   = OUT_FRAC;
   localparam int CSR_IDX_W = 2;

   localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(1) << OUT_FRAC;

   localparam logic [1:0] FUNC_Z  = 2'd0;
   localparam logic [1:0] FUNC_S  = 2'd1;
   localparam logic [1:0] FUNC_PI = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_C = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_D = 2'd3;

   localparam logic signed [IN_W-1:0] POINT_A_RST = -16'sd2560;
   localparam logic signed [IN_W-1:0] POINT_B_RST = 16'sd2560;
   localparam logic signed [IN_W-1:0] POINT_C_RST = 16'sd768;
   localparam logic signed [IN_W-1:0] POINT_D_RST = 16'sd2560;

   typedef struct packed {
      logic spline;
      logic upper;
      logic one;
      logic invert;
      logic deg;
   } ctrl_type;

endpackage
`default_nettype wire

/* rtl/fuzzy_membership_eval_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_membership_eval_core
// Z, S and Pi spline membership degree of a signed Q8.8 sample, Q1.15 out.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side keeps up: one decode
// stage, one squaring stage, a chain of 15 division cells that each settle
// one quotient bit of 2*(t/w)^2, and the output register. The division chain
// sets the latency; any stage that holds a request stalls only the stages
// behind it, so bubbles are squeezed out. The user must write the point
// registers through the csr_ port only while no request is in flight; the
// block does not enforce it. Reset: a = -10.0, b = 10.0, c = 3.0, d = 10.0.
// ----------------------------------------------------------------------------
module fuzzy_membership_eval_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [fme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fme_pkg::IN_W-1:0]          csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_func,
   input  wire logic signed [fme_pkg::IN_W-1:0]   req_x_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [fme_pkg::OUT_W-1:0]              rsp_membership,
   output logic                                   rsp_degenerate
);
   import fme_pkg::*;

   logic signed [IN_W-1:0] point_a_ff, point_b_ff, point_c_ff, point_d_ff;

   logic            fr_valid, fr_ready;
   logic [IN_W-1:0] fr_t, fr_w;
   ctrl_type        fr_ctrl;

   logic              ch_valid [QUOT_W+1];
   logic              ch_ready [QUOT_W+1];
   logic [REM_W-1:0]  ch_rem   [QUOT_W+1];
   logic [SQ_W-1:0]   ch_den   [QUOT_W+1];
   logic [QUOT_W-1:0] ch_quot  [QUOT_W+1];
   ctrl_type          ch_ctrl  [QUOT_W+1];

   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  membership_ff, membership_in;
   logic              degenerate_ff;
   logic [OUT_W-1:0]  spline_val, base_val;
   ctrl_type          tail;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_a_ff <= POINT_A_RST;
         point_b_ff <= POINT_B_RST;
         point_c_ff <= POINT_C_RST;
         point_d_ff <= POINT_D_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POINT_A: point_a_ff <= $signed(csr_wdata);
            CSR_POINT_B: point_b_ff <= $signed(csr_wdata);
            CSR_POINT_C: point_c_ff <= $signed(csr_wdata);
            CSR_POINT_D: point_d_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   fme_front u_front (
      .clock       (clock),
      .reset       (reset),
      .point_a     (point_a_ff),
      .point_b     (point_b_ff),
      .point_c     (point_c_ff),
      .point_d     (point_d_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_x_value (req_x_value),
      .dn_valid    (fr_valid),
      .dn_ready    (fr_ready),
      .dn_t        (fr_t),
      .dn_w        (fr_w),
      .dn_ctrl     (fr_ctrl)
   );

   fme_square u_square (
      .clock    (clock),
      .reset    (reset),
      .up_valid (fr_valid),
      .up_ready (fr_ready),
      .up_t     (fr_t),
      .up_w     (fr_w),
      .up_ctrl  (fr_ctrl),
      .dn_valid (ch_valid[0]),
      .dn_ready (ch_ready[0]),
      .dn_rem   (ch_rem[0]),
      .dn_den   (ch_den[0]),
      .dn_ctrl  (ch_ctrl[0])
   );

   assign ch_quot[0] = '0;

   for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
      fme_div_cell #(
         .SHIFT (QUOT_W - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (ch_valid[i]),
         .up_ready (ch_ready[i]),
         .up_rem   (ch_rem[i]),
         .up_den   (ch_den[i]),
         .up_quot  (ch_quot[i]),
         .up_ctrl  (ch_ctrl[i]),
         .dn_valid (ch_valid[i+1]),
         .dn_ready (ch_ready[i+1]),
         .dn_rem   (ch_rem[i+1]),
         .dn_den   (ch_den[i+1]),
         .dn_quot  (ch_quot[i+1]),
         .dn_ctrl  (ch_ctrl[i+1])
      );
   end

   always_comb begin
      tail       = ch_ctrl[QUOT_W];
      spline_val = tail.upper ? (ONE_Q - OUT_W'(ch_quot[QUOT_W])) : OUT_W'(ch_quot[QUOT_W]);
      if (tail.spline) begin
         base_val = spline_val;
      end else begin
         base_val = tail.one ? ONE_Q : '0;
      end
      membership_in = tail.invert ? (ONE_Q - base_val) : base_val;
   end

   assign ch_ready[QUOT_W] = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ch_ready[QUOT_W]) begin
         rsp_valid_ff <= ch_valid[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ch_ready[QUOT_W] && ch_valid[QUOT_W]) begin
         membership_ff <= membership_in;
         degenerate_ff <= tail.deg;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_membership = membership_ff;
   assign rsp_degenerate = degenerate_ff;

endmodule
`default_nettype wire

/* rtl/fme_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fme_front
// Shape decode: picks the segment, handles steps and saturated regions and
// registers the spline distance and width.
// ----------------------------------------------------------------------------
module fme_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic signed [fme_pkg::IN_W-1:0] point_a,
   input  wire logic signed [fme_pkg::IN_W-1:0] point_b,
   input  wire logic signed [fme_pkg::IN_W-1:0] point_c,
   input  wire logic signed [fme_pkg::IN_W-1:0] point_d,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_func,
   input  wire logic signed [fme_pkg::IN_W-1:0] req_x_value,
   output logic                               dn_valid,
   input  wire logic                          dn_ready,
   output logic [fme_pkg::IN_W-1:0]           dn_t,
   output logic [fme_pkg::IN_W-1:0]           dn_w,
   output fme_pkg::ctrl_type                  dn_ctrl
);
   import fme_pkg::*;

   logic                    valid_ff;
   logic [IN_W-1:0]         t_ff, t_in;
   logic [IN_W-1:0]         w_ff, w_in;
   ctrl_type                ctrl_ff, ctrl_in;
   logic                    use_cd;
   logic signed [IN_W-1:0]  p, q;
   logic signed [IN_W:0]    pq_sum, x2;
   logic [IN_W:0]           w_d, t_lo, t_hi;

   always_comb begin
      use_cd = (req_func == FUNC_PI) && (req_x_value > point_b) && (req_x_value < point_d);
      p      = use_cd ? point_c : point_a;
      q      = use_cd ? point_d : point_b;
      pq_sum = $signed({p[IN_W-1], p}) + $signed({q[IN_W-1], q});
      x2     = $signed({req_x_value, 1'b0});
      w_d    = {q[IN_W-1], q} - {p[IN_W-1], p};
      t_lo   = {req_x_value[IN_W-1], req_x_value} - {p[IN_W-1], p};
      t_hi   = {q[IN_W-1], q} - {req_x_value[IN_W-1], req_x_value};
      ctrl_in = '0;
      t_in    = '0;
      w_in    = '0;
      case (req_func)
         FUNC_Z, FUNC_S, FUNC_PI: begin
            if (req_func == FUNC_PI) begin
               ctrl_in.deg    = (point_b <= point_a) || (point_d <= point_c);
               ctrl_in.invert = use_cd;
            end else begin
               ctrl_in.invert = (req_func == FUNC_Z);
            end
            if ((req_func == FUNC_PI) && (req_x_value >= point_d)) begin
               ctrl_in.one = 1'b0;
            end else if (q <= p) begin
               ctrl_in.deg = 1'b1;
               ctrl_in.one = (req_x_value > p);
            end else if (req_x_value <= p) begin
               ctrl_in.one = 1'b0;
            end else if (req_x_value >= q) begin
               ctrl_in.one = 1'b1;
            end else begin
               ctrl_in.spline = 1'b1;
               w_in = w_d[IN_W-1:0];
               if (x2 <= pq_sum) begin
                  t_in = t_lo[IN_W-1:0];
               end else begin
                  ctrl_in.upper = 1'b1;
                  t_in = t_hi[IN_W-1:0];
               end
            end
         end
         default: begin
            ctrl_in = '0;
         end
      endcase
   end

   assign req_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         t_ff    <= t_in;
         w_ff    <= w_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_t     = t_ff;
   assign dn_w     = w_ff;
   assign dn_ctrl  = ctrl_ff;

endmodule
`default_nettype wire

/* rtl/fme_square.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fme_square
// Squares distance and width and forms the rounded dividend.
// ----------------------------------------------------------------------------
module fme_square (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        up_valid,
   output logic                             up_ready,
   input  wire logic [fme_pkg::IN_W-1:0]    up_t,
   input  wire logic [fme_pkg::IN_W-1:0]    up_w,
   input  wire fme_pkg::ctrl_type           up_ctrl,
   output logic                             dn_valid,
   input  wire logic                        dn_ready,
   output logic [fme_pkg::REM_W-1:0]        dn_rem,
   output logic [fme_pkg::SQ_W-1:0]         dn_den,
   output fme_pkg::ctrl_type                dn_ctrl
);
   import fme_pkg::*;

   logic              valid_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SQ_W-1:0]   den_ff, den_in;
   ctrl_type          ctrl_ff;
   logic [SQ_W-1:0]   t_sq;

   always_comb begin
      t_sq   = up_t * up_t;
      den_in = up_w * up_w;
      rem_in = {t_sq, {SCALE{1'b0}}} + REM_W'(den_in >> 1);
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         ctrl_ff <= up_ctrl;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_den   = den_ff;
   assign dn_ctrl  = ctrl_ff;

endmodule
`default_nettype wire

/* rtl/fme_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fme_div_cell
// One restoring division step: resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
module fme_div_cell #(
   parameter int SHIFT = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        up_valid,
   output logic                             up_ready,
   input  wire logic [fme_pkg::REM_W-1:0]   up_rem,
   input  wire logic [fme_pkg::SQ_W-1:0]    up_den,
   input  wire logic [fme_pkg::QUOT_W-1:0]  up_quot,
   input  wire fme_pkg::ctrl_type           up_ctrl,
   output logic                             dn_valid,
   input  wire logic                        dn_ready,
   output logic [fme_pkg::REM_W-1:0]        dn_rem,
   output logic [fme_pkg::SQ_W-1:0]         dn_den,
   output logic [fme_pkg::QUOT_W-1:0]       dn_quot,
   output fme_pkg::ctrl_type                dn_ctrl
);
   import fme_pkg::*;

   logic               valid_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SQ_W-1:0]    den_ff;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   ctrl_type           ctrl_ff;
   logic [REM_W-1:0]   trial;
   logic               fits;

   always_comb begin
      trial   = REM_W'(up_den) << SHIFT;
      fits    = (up_rem >= trial);
      rem_in  = fits ? (up_rem - trial) : up_rem;
      quot_in = {up_quot[QUOT_W-2:0], fits};
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rem_ff  <= rem_in;
         den_ff  <= up_den;
         quot_ff <= quot_in;
         ctrl_ff <= up_ctrl;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_den   = den_ff;
   assign dn_quot  = quot_ff;
   assign dn_ctrl  = ctrl_ff;

endmodule
`default_nettype wire
